// ===== sv/ale_pkg.sv =====
// ----------------------------------------------------------------------------
// ale_pkg
// Shared types, codes and sizes for the array list engine.
// ----------------------------------------------------------------------------
package ale_pkg;

  localparam int LIST_DEPTH = 256;
  localparam int IDX_W = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
  localparam int CNT_W = $clog2(LIST_DEPTH + 1);
  localparam int CAP_W = 9;
  localparam int CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;
  localparam logic [CAP_W-1:0] CAP_RESET = 9'd256;

  localparam logic [2:0] CMD_READ    = 3'd0;
  localparam logic [2:0] CMD_APPEND  = 3'd1;
  localparam logic [2:0] CMD_INSERT  = 3'd2;
  localparam logic [2:0] CMD_REMOVE  = 3'd3;
  localparam logic [2:0] CMD_LSEARCH = 3'd4;
  localparam logic [2:0] CMD_BSEARCH = 3'd5;
  localparam logic [2:0] CMD_SORT    = 3'd6;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_FULL     = 3'd1;
  localparam logic [2:0] ST_EMPTY    = 3'd2;
  localparam logic [2:0] ST_INDEX    = 3'd3;
  localparam logic [2:0] ST_NOTFOUND = 3'd4;
  localparam logic [2:0] ST_UNSORTED = 3'd5;

  typedef struct packed {
    logic [2:0]         cmd;
    logic [7:0]         position;
    logic signed [31:0] operand_value;
  } in_item_t;

  typedef struct packed {
    logic [2:0]         status;
    logic [7:0]         found_position;
    logic signed [31:0] read_data;
    logic [8:0]         entry_total;
    logic               is_ordered;
  } out_item_t;

  typedef enum logic [2:0] {
    C_HOLD, C_LOAD, C_LEFT, C_RIGHT, C_MIN, C_MAX
  } cell_op_t;

  typedef struct packed {
    cell_op_t           op;
    logic signed [31:0] load_word;
  } cell_ctrl_t;

  typedef enum logic [1:0] {
    S_IDLE, S_LSRCH, S_BSRCH, S_SORT
  } state_t;

endpackage

// ===== sv/array_list_engine.sv =====
// ----------------------------------------------------------------------------
// array_list_engine
// Ordered list of signed words held in a chain of cells, with read, append,
// insert, remove, linear and binary search, and sort.
// ----------------------------------------------------------------------------
// Read, append, insert and remove are done as soon as they are taken, since
// every cell moves to its neighbor in the same cycle. Linear search walks
// the list one entry per cycle and binary search takes one probe per cycle,
// both while the output slot is free; sort runs an odd-even transposition
// over the chain, one pass per cycle, count passes in all, with the last
// pass held until the output slot is free.
// One command is worked on at a time; a new command is taken only while the
// output slot is free. The store holds no reset value; only entries below
// the count are ever read.
module array_list_engine import ale_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  in_item_t         in_data,
  output logic             out_valid,
  input  logic             out_stall,
  output out_item_t        out_data,
  input  logic             cfg_we,
  input  logic [CAP_W-1:0] cfg_wdata
);

  state_t state_r, state_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic sorted_r, sorted_nxt;
  logic [CAP_W-1:0] cap_r;
  logic [CNT_W-1:0] idx_r, idx_nxt, lo_r, lo_nxt, hi_r, hi_nxt;
  logic signed [31:0] val_r, val_nxt;
  logic out_valid_r, out_valid_nxt;
  out_item_t out_data_r, out_data_nxt;

  logic signed [31:0] words [LIST_DEPTH];

  // The output slot is free when empty or being drained in this cycle.
  logic out_free, accept;
  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = !(state_r == S_IDLE && out_free);
  assign accept = in_valid && !in_stall;

  logic [CMP_W-1:0] cnt_c, pos_c, eff_cap;
  assign cnt_c = CMP_W'(count_r);
  assign pos_c = CMP_W'(in_data.position);
  assign eff_cap = (CMP_W'(cap_r) < CMP_W'(LIST_DEPTH)) ? CMP_W'(cap_r)
                                                        : CMP_W'(LIST_DEPTH);

  logic do_append, do_insert, do_remove;
  assign do_append = accept && in_data.cmd == CMD_APPEND && cnt_c < eff_cap;
  assign do_insert = accept && in_data.cmd == CMD_INSERT && pos_c < cnt_c &&
                     cnt_c < eff_cap;
  assign do_remove = accept && in_data.cmd == CMD_REMOVE && cnt_c != '0 &&
                     pos_c < cnt_c;

  // Sort: idx_r counts passes. The last pass runs only once the result can
  // be written, so the chain never runs ahead of the reported result.
  logic sort_last, sort_go, phase;
  assign sort_last = (CMP_W'(idx_r) + CMP_W'(1)) >= cnt_c;
  assign sort_go = state_r == S_SORT && (!sort_last || out_free);
  assign phase = idx_r[0];

  for (genvar i = 0; i < LIST_DEPTH; i++) begin : g_cell
    localparam logic [CMP_W-1:0] I = CMP_W'(i);
    localparam logic PAR = (i % 2) == 1;
    cell_ctrl_t ctrl;
    logic signed [31:0] lw, rw;

    assign lw = (i == 0) ? 32'sd0 : words[(i == 0) ? 0 : i - 1];
    assign rw = (i == LIST_DEPTH - 1) ? 32'sd0
                                      : words[(i == LIST_DEPTH - 1) ? i : i + 1];

    always_comb begin
      ctrl.load_word = in_data.operand_value;
      ctrl.op = C_HOLD;
      if (do_append) begin
        if (I == cnt_c) ctrl.op = C_LOAD;
      end else if (do_insert) begin
        if (I == pos_c) ctrl.op = C_LOAD;
        else if (I > pos_c && I <= cnt_c) ctrl.op = C_LEFT;
      end else if (do_remove) begin
        if (I >= pos_c && I + CMP_W'(1) < cnt_c) ctrl.op = C_RIGHT;
      end else if (sort_go) begin
        if (PAR == phase && I + CMP_W'(1) < cnt_c) ctrl.op = C_MIN;
        else if (i != 0 && PAR != phase && I < cnt_c) ctrl.op = C_MAX;
      end
    end

    ale_cell u_cell (
      .clk       (clk),
      .ctrl      (ctrl),
      .left_word (lw),
      .right_word(rw),
      .word      (words[i])
    );
  end

  // Binary search probe: midpoint of the half-open range, rounded down.
  logic [CNT_W:0] mid_sum;
  logic [CNT_W-1:0] mid;
  assign mid_sum = {1'b0, lo_r} + {1'b0, hi_r} - (CNT_W+1)'(1);
  assign mid = mid_sum[CNT_W:1];

  // One shared read port on the chain: the walk index during linear search,
  // the probe during binary search, and the command position otherwise.
  logic [IDX_W-1:0] rd_addr;
  logic signed [31:0] rd_word;
  always_comb begin
    case (state_r)
      S_LSRCH: rd_addr = idx_r[IDX_W-1:0];
      S_BSRCH: rd_addr = mid[IDX_W-1:0];
      default: rd_addr = IDX_W'(in_data.position);
    endcase
  end
  assign rd_word = words[rd_addr];

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (in_data.cmd == CMD_LSEARCH) state_nxt = S_LSRCH;
          else if (in_data.cmd == CMD_BSEARCH && sorted_r) state_nxt = S_BSRCH;
          else if (in_data.cmd == CMD_SORT && cnt_c > CMP_W'(1)) state_nxt = S_SORT;
        end
      end
      S_LSRCH: begin
        if (out_free && (idx_r >= count_r || rd_word == val_r)) state_nxt = S_IDLE;
      end
      S_BSRCH: begin
        if (out_free && (lo_r >= hi_r || rd_word == val_r)) state_nxt = S_IDLE;
      end
      S_SORT: begin
        if (sort_go && sort_last) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Datapath registers and result. A waiting result keeps its payload; the
  // status, position and data fields are cleared only when a command is
  // taken, and a search fills them in when it finishes.
  always_comb begin
    count_nxt = count_r;
    sorted_nxt = sorted_r;
    idx_nxt = idx_r;
    lo_nxt = lo_r;
    hi_nxt = hi_r;
    val_nxt = val_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt = out_data_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          val_nxt = in_data.operand_value;
          idx_nxt = '0;
          lo_nxt = '0;
          hi_nxt = count_r;
          out_valid_nxt = 1'b1;
          out_data_nxt.status = ST_OK;
          out_data_nxt.found_position = '0;
          out_data_nxt.read_data = '0;
          case (in_data.cmd)
            CMD_READ: begin
              if (pos_c >= cnt_c) out_data_nxt.status = ST_INDEX;
              else out_data_nxt.read_data = rd_word;
            end
            CMD_APPEND: begin
              if (do_append) begin
                count_nxt = count_r + CNT_W'(1);
                sorted_nxt = 1'b0;
              end else begin
                out_data_nxt.status = ST_FULL;
              end
            end
            CMD_INSERT: begin
              if (pos_c >= cnt_c) out_data_nxt.status = ST_INDEX;
              else if (!do_insert) out_data_nxt.status = ST_FULL;
              else begin
                count_nxt = count_r + CNT_W'(1);
                sorted_nxt = 1'b0;
              end
            end
            CMD_REMOVE: begin
              if (cnt_c == '0) out_data_nxt.status = ST_EMPTY;
              else if (pos_c >= cnt_c) out_data_nxt.status = ST_INDEX;
              else count_nxt = count_r - CNT_W'(1);
            end
            CMD_LSEARCH: out_valid_nxt = 1'b0;
            CMD_BSEARCH: begin
              if (sorted_r) out_valid_nxt = 1'b0;
              else out_data_nxt.status = ST_UNSORTED;
            end
            CMD_SORT: begin
              sorted_nxt = 1'b1;
              if (cnt_c > CMP_W'(1)) out_valid_nxt = 1'b0;
            end
            default: ;
          endcase
          out_data_nxt.entry_total = 9'(count_nxt);
          out_data_nxt.is_ordered = sorted_nxt;
        end
      end
      S_LSRCH: begin
        if (out_free) begin
          if (idx_r >= count_r) begin
            out_valid_nxt = 1'b1;
            out_data_nxt.status = ST_NOTFOUND;
          end else if (rd_word == val_r) begin
            out_valid_nxt = 1'b1;
            out_data_nxt.found_position = 8'(idx_r);
          end else begin
            idx_nxt = idx_r + CNT_W'(1);
          end
        end
      end
      S_BSRCH: begin
        if (out_free) begin
          if (lo_r >= hi_r) begin
            out_valid_nxt = 1'b1;
            out_data_nxt.status = ST_NOTFOUND;
          end else if (rd_word == val_r) begin
            out_valid_nxt = 1'b1;
            out_data_nxt.found_position = 8'(mid);
          end else if (val_r < rd_word) begin
            hi_nxt = mid;
          end else begin
            lo_nxt = mid + CNT_W'(1);
          end
        end
      end
      S_SORT: begin
        if (sort_go) begin
          idx_nxt = idx_r + CNT_W'(1);
          if (sort_last) out_valid_nxt = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
      sorted_r <= 1'b0;
      cap_r <= CAP_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      sorted_r <= sorted_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) cap_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    idx_r <= idx_nxt;
    lo_r <= lo_nxt;
    hi_r <= hi_nxt;
    val_r <= val_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data = out_data_r;

endmodule

// ===== sv/ale_cell.sv =====
// ----------------------------------------------------------------------------
// ale_cell
// One list slot: holds a word and takes it from a neighbor, the load bus,
// or the min or max of itself and a neighbor for a compare-exchange.
// ----------------------------------------------------------------------------
module ale_cell import ale_pkg::*; (
  input  logic               clk,
  input  cell_ctrl_t         ctrl,
  input  logic signed [31:0] left_word,
  input  logic signed [31:0] right_word,
  output logic signed [31:0] word
);

  logic signed [31:0] word_r, word_nxt;

  always_comb begin
    case (ctrl.op)
      C_LOAD:  word_nxt = ctrl.load_word;
      C_LEFT:  word_nxt = left_word;
      C_RIGHT: word_nxt = right_word;
      C_MIN:   word_nxt = (right_word < word_r) ? right_word : word_r;
      C_MAX:   word_nxt = (left_word > word_r) ? left_word : word_r;
      default: word_nxt = word_r;
    endcase
  end

  always_ff @(posedge clk) begin
    word_r <= word_nxt;
  end

  assign word = word_r;

endmodule

// ===== bench/array_list_engine_test.sv =====
// ----------------------------------------------------------------------------
// array_list_engine_test
// Self-checking bench for the array list engine: a directed table of
// commands followed by constrained-by-hand random traffic, every result
// compared against a typed table result or a behavioral list model in the bench.
// ----------------------------------------------------------------------------
module array_list_engine_test;
  import ale_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_ITEMS = 252;
  localparam int STALL_LIMIT  = 20000;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;
  logic      cfg_we = 1'b0;
  logic [CAP_W-1:0] cfg_wdata = '0;

  always #6 clk = ~clk;

  array_list_engine u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  // Bench-side copy of the list state.
  logic signed [31:0] shadow_words [LIST_DEPTH];
  int unsigned        shadow_count;
  logic               shadow_sorted;
  int unsigned        shadow_cap;

  out_item_t   pending_results [$];
  int unsigned mismatch_count;
  int unsigned result_count;
  int unsigned transfer_count;
  int unsigned quiet_cycles;
  bit          idle_enable;
  bit          hold_off;

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("MISMATCH %s: got %0h expected %0h at %0t", what, got, want, $realtime);
    mismatch_count++;
  endtask

  // Computes the result of one command and advances the bench's list state.
  function automatic out_item_t list_step(input in_item_t cmd_item);
    out_item_t r;
    int unsigned lo, hi, mid, j, k;
    logic signed [31:0] held;
    r = '0;
    r.status = ST_OK;
    case (cmd_item.cmd)
      CMD_READ: begin
        if (cmd_item.position >= shadow_count) r.status = ST_INDEX;
        else r.read_data = shadow_words[cmd_item.position];
      end
      CMD_APPEND: begin
        if (shadow_count >= shadow_cap) r.status = ST_FULL;
        else begin
          shadow_words[shadow_count] = cmd_item.operand_value;
          shadow_count++;
          shadow_sorted = 1'b0;
        end
      end
      CMD_INSERT: begin
        if (cmd_item.position >= shadow_count) r.status = ST_INDEX;
        else if (shadow_count >= shadow_cap) r.status = ST_FULL;
        else begin
          for (j = shadow_count; j > cmd_item.position; j--)
            shadow_words[j] = shadow_words[j-1];
          shadow_words[cmd_item.position] = cmd_item.operand_value;
          shadow_count++;
          shadow_sorted = 1'b0;
        end
      end
      CMD_REMOVE: begin
        if (shadow_count == 0) r.status = ST_EMPTY;
        else if (cmd_item.position >= shadow_count) r.status = ST_INDEX;
        else begin
          for (j = cmd_item.position; j + 1 < shadow_count; j++)
            shadow_words[j] = shadow_words[j+1];
          shadow_count--;
        end
      end
      CMD_LSEARCH: begin
        r.status = ST_NOTFOUND;
        for (j = 0; j < shadow_count; j++)
          if (shadow_words[j] == cmd_item.operand_value) begin
            r.status = ST_OK;
            r.found_position = j[7:0];
            break;
          end
      end
      CMD_BSEARCH: begin
        if (!shadow_sorted) r.status = ST_UNSORTED;
        else begin
          // Half-open window, midpoint rounded down; first hit wins.
          lo = 0;
          hi = shadow_count;
          r.status = ST_NOTFOUND;
          while (lo < hi) begin
            mid = (lo + hi - 1) / 2;
            if (shadow_words[mid] == cmd_item.operand_value) begin
              r.status = ST_OK;
              r.found_position = mid[7:0];
              break;
            end else if (cmd_item.operand_value < shadow_words[mid]) hi = mid;
            else lo = mid + 1;
          end
        end
      end
      CMD_SORT: begin
        for (j = 1; j < shadow_count; j++) begin
          held = shadow_words[j];
          k = j;
          while (k > 0 && held < shadow_words[k-1]) begin
            shadow_words[k] = shadow_words[k-1];
            k--;
          end
          shadow_words[k] = held;
        end
        shadow_sorted = 1'b1;
      end
      default: ;
    endcase
    r.entry_total = shadow_count[8:0];
    r.is_ordered  = shadow_sorted;
    return r;
  endfunction

  // Result side: random stall, and comparison of every accepted transfer
  // against the oldest pending expectation.
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      result_count++;
      if (pending_results.size() == 0) begin
        $display("MISMATCH unexpected result %0h at %0t", out_data, $realtime);
        mismatch_count++;
      end else begin
        want = pending_results.pop_front();
        if (out_data.status !== want.status)
          report_mismatch("status", out_data.status, want.status);
        if (out_data.found_position !== want.found_position)
          report_mismatch("found_position", out_data.found_position, want.found_position);
        if (out_data.read_data !== want.read_data)
          report_mismatch("read_data", out_data.read_data, want.read_data);
        if (out_data.entry_total !== want.entry_total)
          report_mismatch("entry_total", out_data.entry_total, want.entry_total);
        if (out_data.is_ordered !== want.is_ordered)
          report_mismatch("is_ordered", out_data.is_ordered, want.is_ordered);
      end
    end
    out_stall <= idle_enable && ($urandom_range(99) < 34);
  end

  // Watchdog: the run is declared hung if no transfer on either side is seen
  // for a long stretch. A full sort of 256 entries is far below this.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("Watchdog expired after %0d idle cycles", quiet_cycles);
      $display("Regression FAIL");
      $finish;
    end
  end

  // Sends one command: optional random gap first, then valid held until the
  // transfer. Valid is only lowered when no item follows right away.
  task automatic send_item(input in_item_t item, input bit check_typed,
                           input out_item_t typed);
    out_item_t want;
    while (idle_enable && ($urandom_range(99) < 34)) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    transfer_count++;
    want = list_step(item);
    if (check_typed && want !== typed)
      $display("Note: table row %0h disagrees with bench model", typed);
    pending_results.push_back(check_typed ? typed : want);
  endtask

  // Waits until every result has come back, then lets the block settle.
  task automatic drain;
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_capacity(input int unsigned cap);
    cfg_we    <= 1'b1;
    cfg_wdata <= cap[CAP_W-1:0];
    @(posedge clk);
    cfg_we    <= 1'b0;
    shadow_cap = (cap < LIST_DEPTH) ? cap : LIST_DEPTH;
    @(posedge clk);
  endtask

  // Directed table. The typed result is used only where it is obvious from
  // the command; other rows fall back to the bench model.
  typedef struct {
    in_item_t  item;
    bit        typed;
    out_item_t result;
  } table_row_t;

  function automatic table_row_t row(input logic [2:0] c, input logic [7:0] p,
                                     input logic signed [31:0] v, input bit t,
                                     input logic [2:0] st, input logic [8:0] n,
                                     input logic o);
    table_row_t x;
    x.item = '{cmd: c, position: p, operand_value: v};
    x.typed = t;
    x.result = '{status: st, found_position: 8'd0, read_data: 32'sd0,
                 entry_total: n, is_ordered: o};
    return x;
  endfunction

  // Picks a value that is often already in the list so searches hit.
  function automatic logic signed [31:0] pick_value;
    int unsigned sel;
    sel = $urandom_range(9);
    if (sel < 4 && shadow_count != 0)
      return shadow_words[$urandom_range(shadow_count - 1)];
    if (sel == 4) return $urandom_range(1) ? 32'sh7fffffff : 32'sh80000000;
    if (sel == 5) return $signed($urandom_range(7)) - 3;
    return $signed($urandom);
  endfunction

  function automatic in_item_t random_item;
    in_item_t it;
    int unsigned roll;
    roll = $urandom_range(99);
    it.operand_value = pick_value();
    if (roll < 30)      it.cmd = CMD_APPEND;
    else if (roll < 42) it.cmd = CMD_INSERT;
    else if (roll < 56) it.cmd = CMD_REMOVE;
    else if (roll < 68) it.cmd = CMD_READ;
    else if (roll < 78) it.cmd = CMD_LSEARCH;
    else if (roll < 90) it.cmd = CMD_BSEARCH;
    else if (roll < 97) it.cmd = CMD_SORT;
    else                it.cmd = 3'd7;
    // Mostly positions inside the list, sometimes anywhere in the field.
    if (shadow_count != 0 && $urandom_range(3) != 0)
      it.position = 8'($urandom_range(shadow_count - 1));
    else
      it.position = 8'($urandom_range(255));
    return it;
  endfunction

  initial begin
    table_row_t dir_rows [$];
    int unsigned caps [6];
    int unsigned n, phase;
    shadow_count   = 0;
    shadow_sorted  = 1'b0;
    shadow_cap     = LIST_DEPTH;
    mismatch_count = 0;
    result_count   = 0;
    transfer_count = 0;
    quiet_cycles   = 0;
    idle_enable    = 1'b0;
    foreach (shadow_words[i]) shadow_words[i] = '0;

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part: empty-list refusals, extremes of the words, every
    // command, insert at the end, unused code, binary search on an unsorted
    // list and on a sorted one.
    dir_rows.push_back(row(CMD_READ,    8'd0,   32'sd0, 1, ST_INDEX,    9'd0, 1'b0));
    dir_rows.push_back(row(CMD_REMOVE,  8'd0,   32'sd0, 1, ST_EMPTY,    9'd0, 1'b0));
    dir_rows.push_back(row(CMD_INSERT,  8'd0,   32'sd5, 1, ST_INDEX,    9'd0, 1'b0));
    dir_rows.push_back(row(CMD_LSEARCH, 8'd0,   32'sd5, 1, ST_NOTFOUND, 9'd0, 1'b0));
    dir_rows.push_back(row(CMD_BSEARCH, 8'd0,   32'sd5, 1, ST_UNSORTED, 9'd0, 1'b0));
    dir_rows.push_back(row(CMD_SORT,    8'd0,   32'sd0, 1, ST_OK,       9'd0, 1'b1));
    dir_rows.push_back(row(CMD_BSEARCH, 8'd0,   32'sd5, 1, ST_NOTFOUND, 9'd0, 1'b1));
    dir_rows.push_back(row(CMD_APPEND,  8'd0,   32'sh7fffffff, 1, ST_OK, 9'd1, 1'b0));
    dir_rows.push_back(row(CMD_APPEND,  8'd255, 32'sh80000000, 1, ST_OK, 9'd2, 1'b0));
    dir_rows.push_back(row(CMD_APPEND,  8'd0,   -32'sd1, 1, ST_OK,      9'd3, 1'b0));
    dir_rows.push_back(row(CMD_INSERT,  8'd3,   32'sd0, 1, ST_INDEX,    9'd3, 1'b0));
    dir_rows.push_back(row(CMD_INSERT,  8'd1,   32'sd0, 0, ST_OK,       9'd4, 1'b0));
    dir_rows.push_back(row(CMD_READ,    8'd0,   32'sd0, 0, ST_OK,       9'd4, 1'b0));
    dir_rows.push_back(row(CMD_READ,    8'd255, 32'sd0, 1, ST_INDEX,    9'd4, 1'b0));
    dir_rows.push_back(row(CMD_LSEARCH, 8'd0,   -32'sd1, 0, ST_OK,      9'd4, 1'b0));
    dir_rows.push_back(row(CMD_BSEARCH, 8'd0,   -32'sd1, 1, ST_UNSORTED, 9'd4, 1'b0));
    dir_rows.push_back(row(3'd7,        8'd170, 32'sh55555555, 1, ST_OK, 9'd4, 1'b0));
    dir_rows.push_back(row(CMD_SORT,    8'd0,   32'sd0, 1, ST_OK,       9'd4, 1'b1));
    dir_rows.push_back(row(CMD_BSEARCH, 8'd0,   32'sh80000000, 0, ST_OK, 9'd4, 1'b1));
    dir_rows.push_back(row(CMD_BSEARCH, 8'd0,   32'sh7fffffff, 0, ST_OK, 9'd4, 1'b1));
    dir_rows.push_back(row(CMD_BSEARCH, 8'd0,   32'sd9, 1, ST_NOTFOUND, 9'd4, 1'b1));
    dir_rows.push_back(row(CMD_REMOVE,  8'd4,   32'sd0, 1, ST_INDEX,    9'd4, 1'b1));
    dir_rows.push_back(row(CMD_REMOVE,  8'd3,   32'sd0, 1, ST_OK,       9'd3, 1'b1));
    dir_rows.push_back(row(CMD_REMOVE,  8'd0,   32'sd0, 1, ST_OK,       9'd2, 1'b1));
    foreach (dir_rows[i]) send_item(dir_rows[i].item, dir_rows[i].typed, dir_rows[i].result);
    drain();

    // A capacity of two with two entries held: append and insert refuse.
    write_capacity(2);
    send_item('{cmd: CMD_APPEND, position: 8'd0, operand_value: 32'sd1}, 1,
              '{status: ST_FULL, found_position: 8'd0, read_data: 32'sd0,
                entry_total: 9'd2, is_ordered: 1'b1});
    send_item('{cmd: CMD_INSERT, position: 8'd0, operand_value: 32'sd1}, 1,
              '{status: ST_FULL, found_position: 8'd0, read_data: 32'sd0,
                entry_total: 9'd2, is_ordered: 1'b1});
    drain();

    // Random phases under a sequence of capacities, extremes included.
    // The first phase runs without idling; later phases idle both sides.
    caps = '{256, 1, 0, 9, 511, 256};
    for (phase = 0; phase < 6; phase++) begin
      write_capacity(caps[phase]);
      idle_enable = (phase != 0);
      for (n = 0; n < RANDOM_ITEMS / 6; n++) begin
        send_item(random_item(), 0, '0);
        // Once per phase, hold the sender until every result is back.
        if (n == 40) drain();
      end
      drain();
    end

    // Fill to the full depth with small values, try one more append, sort, and then send random commands.
    idle_enable = 1'b1;
    while (shadow_count < LIST_DEPTH)
      send_item('{cmd: CMD_APPEND, position: 8'd0,
                  operand_value: $signed($urandom_range(600)) - 300}, 0, '0);
    send_item('{cmd: CMD_APPEND, position: 8'd0, operand_value: 32'sd0}, 0, '0);
    send_item('{cmd: CMD_SORT, position: 8'd0, operand_value: 32'sd0}, 0, '0);
    for (n = 0; n < 12; n++) send_item(random_item(), 0, '0);
    drain();

    $display("Covered %0d command transfers and %0d results over six capacity settings,",
             transfer_count, result_count);
    $display("including empty, full, full-depth and sorted-list searches.");
    if (mismatch_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("%0d mismatches", mismatch_count);
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
